[design/rmq_pkg.sv]
// shared types, widths and codes for the rotation matrix to quaternion pipeline
// no dependencies; imported by every module of the block
package rmq_pkg;

    localparam int unsigned FIELD_W  = 18;
    localparam int unsigned NUM_W    = 19;  // sum or difference of two entries
    localparam int unsigned FACT_W   = 21;  // one factor, signed
    localparam int unsigned TB_W     = 19;  // winning factor, positive
    localparam int unsigned ROOT_W   = 18;  // floor(sqrt(t << 16))
    localparam int unsigned REM_W    = 20;  // square root remainder
    localparam int unsigned RAD_W    = 36;  // t << 16, padded to whole bit pairs
    localparam int unsigned SQ_STEPS = RAD_W / 2;
    localparam int unsigned DIVS_W   = 19;  // divisor s = 2r
    localparam int unsigned QUO_W    = 20;  // quotient bits
    localparam int unsigned DIVD_W   = 36;  // (mag << 16) + s/2
    localparam int unsigned DV_STEPS = QUO_W;
    localparam int unsigned LANES    = 3;

    localparam logic signed [FACT_W-1:0] ONE_Q16 = FACT_W'(65536);
    localparam logic signed [FIELD_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [FIELD_W-1:0] OUT_MIN = -18'sd131072;

    typedef enum logic [2:0] {
        CASE_IDENT = 3'd0,
        CASE_TRACE = 3'd1,
        CASE_X     = 3'd2,
        CASE_Y     = 3'd3,
        CASE_Z     = 3'd4
    } case_t;

    typedef logic signed [NUM_W-1:0] num_t;

    // travels alongside the square root
    typedef struct packed {
        case_t chosen;
        num_t  n2;
        num_t  n1;
        num_t  n0;
    } side_t;

    // travels alongside the dividers
    typedef struct packed {
        case_t             chosen;
        logic [FIELD_W-1:0] big;
    } dside_t;

endpackage

[design/rmq_select.sv]
// factor forming and largest-factor selection, two register stages
// depends on rmq_pkg
module rmq_select (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic signed [rmq_pkg::FIELD_W-1:0] m [9],
    output logic                              out_valid,
    output logic [rmq_pkg::TB_W-1:0]          tbest,
    output rmq_pkg::side_t                    side
);
    import rmq_pkg::*;

    logic                     v1_reg, v2_reg;
    logic signed [FACT_W-1:0] t_reg [4];
    num_t                     d21_reg, d02_reg, d10_reg, a10_reg, a02_reg, a21_reg;
    logic [TB_W-1:0]          tb_reg;
    side_t                    side_reg;

    logic signed [FACT_W-1:0] e00, e11, e22;
    logic signed [FACT_W-1:0] t_next [4];
    logic signed [FACT_W-1:0] best_t;
    case_t                    best;
    side_t                    side_next;

    assign e00 = FACT_W'(m[0]);
    assign e11 = FACT_W'(m[4]);
    assign e22 = FACT_W'(m[8]);

    always_comb
    begin
        t_next[0] = ONE_Q16 + e00 + e11 + e22;
        t_next[1] = ONE_Q16 + e00 - e11 - e22;
        t_next[2] = ONE_Q16 + e11 - e00 - e22;
        t_next[3] = ONE_Q16 + e22 - e00 - e11;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg   <= t_next;
            d21_reg <= NUM_W'(m[7]) - NUM_W'(m[5]);
            d02_reg <= NUM_W'(m[2]) - NUM_W'(m[6]);
            d10_reg <= NUM_W'(m[3]) - NUM_W'(m[1]);
            a10_reg <= NUM_W'(m[3]) + NUM_W'(m[1]);
            a02_reg <= NUM_W'(m[2]) + NUM_W'(m[6]);
            a21_reg <= NUM_W'(m[7]) + NUM_W'(m[5]);
            tb_reg   <= best_t[TB_W-1:0];
            side_reg <= side_next;
        end
    end

    // strict compare, so ties keep the earlier factor
    always_comb
    begin
        best   = CASE_IDENT;
        best_t = '0;
        if (t_reg[0] > best_t) begin best = CASE_TRACE; best_t = t_reg[0]; end
        if (t_reg[1] > best_t) begin best = CASE_X;     best_t = t_reg[1]; end
        if (t_reg[2] > best_t) begin best = CASE_Y;     best_t = t_reg[2]; end
        if (t_reg[3] > best_t) begin best = CASE_Z;     best_t = t_reg[3]; end
        side_next.chosen = best;
        unique case (best)
            CASE_TRACE:
            begin
                side_next.n0 = d21_reg; side_next.n1 = d02_reg; side_next.n2 = d10_reg;
            end
            CASE_X:
            begin
                side_next.n0 = a10_reg; side_next.n1 = a02_reg; side_next.n2 = d21_reg;
            end
            CASE_Y:
            begin
                side_next.n0 = a10_reg; side_next.n1 = a21_reg; side_next.n2 = d02_reg;
            end
            CASE_Z:
            begin
                side_next.n0 = a02_reg; side_next.n1 = a21_reg; side_next.n2 = d10_reg;
            end
            default:
            begin
                side_next.n0 = '0; side_next.n1 = '0; side_next.n2 = '0;
            end
        endcase
    end

    assign out_valid = v2_reg;
    assign tbest     = tb_reg;
    assign side      = side_reg;

endmodule

[design/rmq_sqrt.sv]
// pipelined integer square root, one result bit per stage
// depends on rmq_pkg
module rmq_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [rmq_pkg::TB_W-1:0]     t,
    input  rmq_pkg::side_t               in_side,
    output logic                         out_valid,
    output logic [rmq_pkg::ROOT_W-1:0]   root,
    output rmq_pkg::side_t               out_side
);
    import rmq_pkg::*;

    logic              v_reg    [SQ_STEPS];
    logic [REM_W-1:0]  rem_reg  [SQ_STEPS];
    logic [ROOT_W-1:0] root_reg [SQ_STEPS];
    logic [RAD_W-1:0]  rad_reg  [SQ_STEPS];
    side_t             side_reg [SQ_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++)
        begin : g_step
            logic              pv;
            logic [REM_W-1:0]  prem;
            logic [ROOT_W-1:0] proot;
            logic [RAD_W-1:0]  prad;
            side_t             pside;
            logic [REM_W+1:0]  rsh;
            logic [REM_W-1:0]  trial;
            logic              take;

            if (k == 0)
            begin : g_first
                assign pv    = in_valid;
                assign prem  = '0;
                assign proot = '0;
                assign prad  = {{(RAD_W-TB_W-16){1'b0}}, t, 16'b0};
                assign pside = in_side;
            end
            else
            begin : g_rest
                assign pv    = v_reg[k-1];
                assign prem  = rem_reg[k-1];
                assign proot = root_reg[k-1];
                assign prad  = rad_reg[k-1];
                assign pside = side_reg[k-1];
            end

            assign rsh   = {prem, prad[RAD_W-1 -: 2]};
            assign trial = {proot, 2'b01};
            assign take  = rsh >= {2'b00, trial};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (adv)
                    v_reg[k] <= pv;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k]  <= take ? REM_W'(rsh - {2'b00, trial}) : rsh[REM_W-1:0];
                    root_reg[k] <= {proot[ROOT_W-2:0], take};
                    rad_reg[k]  <= {prad[RAD_W-3:0], 2'b00};
                    side_reg[k] <= pside;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[SQ_STEPS-1];
    assign root      = root_reg[SQ_STEPS-1];
    assign out_side  = side_reg[SQ_STEPS-1];

endmodule

[design/rmq_div.sv]
// three-lane pipelined restoring divider, rounded quotient magnitudes
// depends on rmq_pkg
module rmq_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [rmq_pkg::ROOT_W-1:0]   root,
    input  rmq_pkg::side_t               in_side,
    output logic                         out_valid,
    output logic [rmq_pkg::QUO_W-1:0]    quo [rmq_pkg::LANES],
    output logic                         neg [rmq_pkg::LANES],
    output rmq_pkg::dside_t              out_side
);
    import rmq_pkg::*;

    // prep stage: divisor, rounded dividend, signs, dominant component
    logic               pv_reg;
    logic [DIVS_W-1:0]  ps_reg;
    logic [DIVD_W-1:0]  pd_reg  [LANES];
    logic               pn_reg  [LANES];
    dside_t             pside_reg;

    num_t               nums [LANES];
    logic [NUM_W-1:0]   mag  [LANES];
    logic [ROOT_W:0]    big_w;

    assign nums[0] = in_side.n0;
    assign nums[1] = in_side.n1;
    assign nums[2] = in_side.n2;
    assign big_w   = ({1'b0, root} + 1'b1) >> 1;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            mag[i] = nums[i][NUM_W-1] ? NUM_W'(-nums[i]) : NUM_W'(nums[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (adv)
            pv_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ps_reg           <= {root, 1'b0};
            pside_reg.chosen <= in_side.chosen;
            pside_reg.big    <= big_w[FIELD_W-1:0];
            for (int i = 0; i < LANES; i++)
            begin
                pd_reg[i] <= {1'b0, mag[i], 16'b0} + DIVD_W'(root);
                pn_reg[i] <= nums[i][NUM_W-1];
            end
        end
    end

    logic               v_reg    [DV_STEPS];
    logic [DIVS_W-1:0]  s_reg    [DV_STEPS];
    dside_t             side_reg [DV_STEPS];
    logic [DIVS_W-1:0]  rem_reg  [DV_STEPS][LANES];
    logic [QUO_W-1:0]   lo_reg   [DV_STEPS][LANES];
    logic [QUO_W-1:0]   q_reg    [DV_STEPS][LANES];
    logic               n_reg    [DV_STEPS][LANES];

    genvar k, l;
    generate
        for (k = 0; k < DV_STEPS; k++)
        begin : g_step
            logic              pv;
            logic [DIVS_W-1:0] ps;
            dside_t            pside;

            if (k == 0)
            begin : g_cf
                assign pv    = pv_reg;
                assign ps    = ps_reg;
                assign pside = pside_reg;
            end
            else
            begin : g_cr
                assign pv    = v_reg[k-1];
                assign ps    = s_reg[k-1];
                assign pside = side_reg[k-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (adv)
                    v_reg[k] <= pv;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    s_reg[k]    <= ps;
                    side_reg[k] <= pside;
                end
            end

            for (l = 0; l < LANES; l++)
            begin : g_lane
                logic [DIVS_W-1:0] prem;
                logic [QUO_W-1:0]  plo;
                logic [QUO_W-1:0]  pq;
                logic              pn;
                logic [DIVS_W:0]   rsh;
                logic              take;

                if (k == 0)
                begin : g_lf
                    // upper dividend bits start below the divisor
                    assign prem = DIVS_W'(pd_reg[l][DIVD_W-1:QUO_W]);
                    assign plo  = pd_reg[l][QUO_W-1:0];
                    assign pq   = '0;
                    assign pn   = pn_reg[l];
                end
                else
                begin : g_lr
                    assign prem = rem_reg[k-1][l];
                    assign plo  = lo_reg[k-1][l];
                    assign pq   = q_reg[k-1][l];
                    assign pn   = n_reg[k-1][l];
                end

                assign rsh  = {prem, plo[QUO_W-1]};
                assign take = rsh >= {1'b0, ps};

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        rem_reg[k][l] <= take ? DIVS_W'(rsh - {1'b0, ps}) : rsh[DIVS_W-1:0];
                        lo_reg[k][l]  <= {plo[QUO_W-2:0], 1'b0};
                        q_reg[k][l]   <= {pq[QUO_W-2:0], take};
                        n_reg[k][l]   <= pn;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[DV_STEPS-1];
    assign out_side  = side_reg[DV_STEPS-1];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            quo[i] = q_reg[DV_STEPS-1][i];
            neg[i] = n_reg[DV_STEPS-1][i];
        end
    end

endmodule

[design/rotation_matrix_to_quaternion.sv]
// top level of the rotation matrix to quaternion converter
// depends on rmq_pkg, rmq_select, rmq_sqrt and rmq_div
//
// Converts one 3x3 rotation matrix (signed Q2.16 entries) into a quaternion by
// Shepperd's method: the largest of the four factors 1+trace and 1+mii-mjj-mkk
// picks the case (ties go to the earlier), s = 2*sqrt(t), the dominant
// component is s/4 rounded half up and the other three are off-diagonal sums
// or differences over s, rounded to nearest with ties away from zero and
// saturated to Q2.16. A new matrix can be taken every cycle while the output
// is not stalled. Each item passes in order through factor forming and
// selection, the bit-per-stage square root, divider set-up, the bit-per-stage
// dividers (three lanes in parallel) and saturation with the output register.
// The whole pipe moves as one while the output register is empty or being
// taken, so a stall on the output holds every item in place.
module rotation_matrix_to_quaternion (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (18 bits each), 6 zero bits
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // qx, qy, qz, qw (18 bits each)
    output logic [71:0]  m_axis_tdata,
    // chosen_case (3 bits)
    output logic [2:0]   m_axis_tuser
);
    import rmq_pkg::*;

    logic adv;

    logic signed [FIELD_W-1:0] m [9];

    logic            sel_valid;
    logic [TB_W-1:0] sel_t;
    side_t           sel_side;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    side_t             sq_side;

    logic             dv_valid;
    logic [QUO_W-1:0] dv_quo [LANES];
    logic             dv_neg [LANES];
    dside_t           dv_side;

    logic signed [FIELD_W-1:0] comp [LANES];
    logic signed [FIELD_W-1:0] qx_next, qy_next, qz_next, qw_next;

    logic                      out_v_reg;
    logic signed [FIELD_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    case_t                     case_reg;

    // the pipe advances whenever the output register can take an item
    assign adv           = !out_v_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            m[i] = s_axis_tdata[i*FIELD_W +: FIELD_W];
    end

    rmq_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .m         (m),
        .out_valid (sel_valid),
        .tbest     (sel_t),
        .side      (sel_side)
    );

    rmq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sel_valid),
        .t         (sel_t),
        .in_side   (sel_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    rmq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .root      (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .neg       (dv_neg),
        .out_side  (dv_side)
    );

    // apply the sign and clamp to the q2.16 range
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (dv_neg[i])
                comp[i] = (dv_quo[i] > QUO_W'(131072)) ? OUT_MIN
                                                      : FIELD_W'(-dv_quo[i]);
            else
                comp[i] = (dv_quo[i] > QUO_W'(131071)) ? OUT_MAX
                                                      : FIELD_W'(dv_quo[i]);
        end
    end

    // place the dominant component in its slot
    always_comb
    begin
        unique case (dv_side.chosen)
            CASE_TRACE:
            begin
                qx_next = comp[0]; qy_next = comp[1];
                qz_next = comp[2]; qw_next = dv_side.big;
            end
            CASE_X:
            begin
                qx_next = dv_side.big; qy_next = comp[0];
                qz_next = comp[1];     qw_next = comp[2];
            end
            CASE_Y:
            begin
                qx_next = comp[0]; qy_next = dv_side.big;
                qz_next = comp[1]; qw_next = comp[2];
            end
            CASE_Z:
            begin
                qx_next = comp[0];     qy_next = comp[1];
                qz_next = dv_side.big; qw_next = comp[2];
            end
            default:
            begin
                // no positive factor: identity
                qx_next = '0; qy_next = '0;
                qz_next = '0; qw_next = FIELD_W'(65536);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
            qz_reg   <= qz_next;
            qw_reg   <= qw_next;
            case_reg <= dv_side.chosen;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {qw_reg, qz_reg, qy_reg, qx_reg};
    assign m_axis_tuser  = case_reg;

`ifndef SYNTHESIS
    // the four factors sum to four, so one is always positive
    a_no_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != CASE_IDENT))
        else $error("identity fallback reached");

    // the dominant trace component is s/4 and never negative
    a_trace_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == CASE_TRACE) |-> !m_axis_tdata[71])
        else $error("negative dominant w");

    // a held output must block the input side
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");
`endif

endmodule

[bench/testbench.sv]
// testbench for rotation_matrix_to_quaternion: directed and random matrices
// depends on rmq_pkg and the rotation_matrix_to_quaternion design files
`timescale 1ns / 100ps

module testbench;
    import rmq_pkg::*;

    typedef struct {
        logic [17:0] qx, qy, qz, qw;
        case_t       chosen;
    } quat_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    quat_t pending_quats[$];
    int    mismatches = 0;
    int    cycle_count = 0;
    bit    sink_busy = 1'b0;

    localparam int CYCLE_LIMIT = 400000;

    rotation_matrix_to_quaternion dut (.*);

    always #5 clk = ~clk;

    // runaway guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d", cycle_count);
            $display("** rotation_matrix_to_quaternion: FAILED **");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 64'd4294967295;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= n) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint clamp18(longint v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return v;
    endfunction

    // num / s in q16, nearest with ties away from zero, clamped to 18 bits
    function automatic longint round_div(longint num, longint s);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< 16) + (s >>> 1)) / s;
        return clamp18((num < 0) ? -q : q);
    endfunction

    function automatic quat_t predict_quat(logic [167:0] d);
        longint m[9];
        longint f[5];
        longint s, big, x, y, z, w;
        int best;
        quat_t q;
        for (int i = 0; i < 9; i++)
            m[i] = longint'($signed(d[i*18 +: 18]));
        f[0] = 0;
        f[1] = 65536 + m[0] + m[4] + m[8];
        f[2] = 65536 + m[0] - m[4] - m[8];
        f[3] = 65536 + m[4] - m[0] - m[8];
        f[4] = 65536 + m[8] - m[0] - m[4];
        best = 0;
        for (int i = 1; i < 5; i++)
            if (f[i] > f[best]) best = i;
        x = 0; y = 0; z = 0; w = 65536;
        if (best != 0)
        begin
            s = 2 * longint'(int_sqrt(longint'(f[best]) <<< 16));
            big = clamp18((s + 2) >>> 2);
            // m index: 1=m01 2=m02 3=m10 5=m12 6=m20 7=m21
            case (best)
                1: begin x = round_div(m[7]-m[5], s); y = round_div(m[2]-m[6], s);
                         z = round_div(m[3]-m[1], s); w = big; end
                2: begin x = big; y = round_div(m[3]+m[1], s);
                         z = round_div(m[2]+m[6], s); w = round_div(m[7]-m[5], s); end
                3: begin x = round_div(m[3]+m[1], s); y = big;
                         z = round_div(m[7]+m[5], s); w = round_div(m[2]-m[6], s); end
                default: begin x = round_div(m[2]+m[6], s); y = round_div(m[7]+m[5], s);
                         z = big; w = round_div(m[3]-m[1], s); end
            endcase
        end
        q.qx = x[17:0]; q.qy = y[17:0]; q.qz = z[17:0]; q.qw = w[17:0];
        q.chosen = case_t'(best[2:0]);
        return q;
    endfunction

    task automatic report_mismatch(string what, logic [17:0] got, logic [17:0] want);
        mismatches++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
    endtask

    // one matrix item, data changes at the falling edge
    // valid stays up after acceptance so back to back items need no gap
    task automatic send_matrix(logic [167:0] d);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        pending_quats.push_back(predict_quat(d));
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    function automatic logic [167:0] pack_matrix(int e[9]);
        logic [167:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) d[i*18 +: 18] = e[i][17:0];
        return d;
    endfunction

    // random output backpressure, with quiet stretches
    initial
    begin
        int g;
        forever
        begin
            @(negedge clk);
            if (sink_busy)
            begin
                g = gap_len();
                if (g > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (g) @(negedge clk);
                end
            end
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        quat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_quats.size() == 0)
            begin
                mismatches++;
                $display("unexpected result at cycle %0d", cycle_count);
            end
            else
            begin
                want = pending_quats.pop_front();
                if (m_axis_tdata[17:0] !== want.qx) report_mismatch("qx", m_axis_tdata[17:0], want.qx);
                if (m_axis_tdata[35:18] !== want.qy) report_mismatch("qy", m_axis_tdata[35:18], want.qy);
                if (m_axis_tdata[53:36] !== want.qz) report_mismatch("qz", m_axis_tdata[53:36], want.qz);
                if (m_axis_tdata[71:54] !== want.qw) report_mismatch("qw", m_axis_tdata[71:54], want.qw);
                if (m_axis_tuser !== want.chosen)
                    report_mismatch("chosen_case", 18'(m_axis_tuser), 18'(want.chosen));
            end
        end
    end

    // input goes idle, then wait for every expected result
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_quats.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // identity, all extremes, each dominant case and ties
    task automatic test_directed();
        int e[9];
        int one = 65536;
        e = '{one,0,0, 0,one,0, 0,0,one};          send_matrix(pack_matrix(e));
        e = '{one,0,0, 0,-one,0, 0,0,-one};        send_matrix(pack_matrix(e));
        e = '{-one,0,0, 0,one,0, 0,0,-one};        send_matrix(pack_matrix(e));
        e = '{-one,0,0, 0,-one,0, 0,0,one};        send_matrix(pack_matrix(e));
        e = '{0,-one,0, one,0,0, 0,0,one};         send_matrix(pack_matrix(e));
        // all large negative diagonal gives t1<=0 and ties among the other factors
        e = '{-131072,0,0, 0,-131072,0, 0,0,-131072}; send_matrix(pack_matrix(e));
        e = '{0,0,0, 0,0,0, 0,0,0};                send_matrix(pack_matrix(e));
        e = '{-21846,0,0, 0,-21845,0, 0,0,-21845}; send_matrix(pack_matrix(e));
        // all max, all min, mixed, saturating off-diagonals
        e = '{131071,131071,131071, 131071,131071,131071, 131071,131071,131071};
        send_matrix(pack_matrix(e));
        e = '{-131072,-131072,-131072, -131072,-131072,-131072, -131072,-131072,-131072};
        send_matrix(pack_matrix(e));
        e = '{-131072,131071,-131072, -131072,-131072,131071, 131071,-131072,-131072};
        send_matrix(pack_matrix(e));
        e = '{131071,-131072,131071, 131071,-131072,-131072, 131071,131071,-131072};
        send_matrix(pack_matrix(e));
        e = '{-131072,131071,131071, 131071,-131072,131071, 131071,131071,131071};
        send_matrix(pack_matrix(e));
        e = '{0,-131072,131071, 131071,0,-131072, -131072,131071,0};
        send_matrix(pack_matrix(e));
        // tie between trace and x-dominant cases
        e = '{one,5,7, 9,0,11, 13,15,0};           send_matrix(pack_matrix(e));
        e = '{0,3,0, 3,0,0, 0,0,0};                send_matrix(pack_matrix(e));
    endtask

    // random matrices steered toward each case plus raw noise
    task automatic test_random(int count);
        int e[9];
        logic [167:0] d;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                d = 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
                d[167:162] = '0;
            end
            else
            begin
                for (int i = 0; i < 9; i++) e[i] = $urandom_range(0, 131072) - 65536;
                // push one diagonal entry, or all three, to steer the case choice
                case ($urandom_range(0, 3))
                    0: begin e[0] = 60000; e[4] = 60000; e[8] = 60000; end
                    1: e[0] = 65536 - $urandom_range(0, 4000);
                    2: e[4] = 65536 - $urandom_range(0, 4000);
                    default: e[8] = 65536 - $urandom_range(0, 4000);
                endcase
                d = pack_matrix(e);
            end
            send_matrix(d);
            if (n == count / 2) wait_drained();   // hold off until pipe drains
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        sink_busy = 1'b1;
        test_directed();
        test_random(300);
        sink_busy = 1'b0;
        test_random(130);
        wait_drained();
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("** rotation_matrix_to_quaternion: PASSED **");
        else
            $display("** rotation_matrix_to_quaternion: FAILED **");
        $finish;
    end

endmodule
